// File: rtl/dfhe_pkg.sv
// ============================================================================
// dfhe_pkg
// Shared types, constants and helper functions for the deflate fixed
// Huffman token encoder.
// ============================================================================
package dfhe_pkg;

    typedef enum logic [1:0] {
        OP_HEADER  = 2'd0,
        OP_LITERAL = 2'd1,
        OP_MATCH   = 2'd2,
        OP_END     = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  literal_byte;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
        logic        final_block;
    } token_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } code_byte_t;

    localparam int TOK_BITS_W = 31;
    localparam int TOK_LEN_W  = 6;
    localparam int ACC_W      = 38;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [TOK_BITS_W-1:0] tok_bits;
        logic [TOK_LEN_W-1:0]  tok_len;
        logic                  flush;
    } q_entry_t;

    localparam logic [8:0]  LIT_CODE8_BASE  = 9'h030;
    localparam logic [8:0]  LIT_CODE9_BASE  = 9'h190;
    localparam logic [8:0]  LEN_CODE8_BASE  = 9'h0C0;
    localparam logic [8:0]  LIT_SPLIT       = 9'd144;
    localparam logic [8:0]  LEN_MIN         = 9'd3;
    localparam logic [8:0]  LEN_MAX         = 9'd258;
    localparam logic [8:0]  LEN_MAX_CODE    = 9'h0C5;
    localparam logic [4:0]  LEN_CODE8_SPLIT = 5'd23;
    localparam logic [15:0] DIST_MAX        = 16'd32768;
    localparam logic [8:0]  EOB_CODE        = 9'd0;
    localparam logic [3:0]  EOB_CODE_LEN    = 4'd7;

    function automatic logic [8:0] rev_code(input logic [8:0] code, input logic [3:0] n);
        logic [8:0] r;
        for (int i = 0; i < 9; i++)
        begin
            r[i] = code[8-i];
        end
        return r >> (4'd9 - n);
    endfunction

    function automatic logic [3:0] top_bit15(input logic [14:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 1; i < 15; i++)
        begin
            if (v[i])
            begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: rtl/dfhe_front.sv
// ============================================================================
// dfhe_front
// Classifies one token and forms its complete bit string: fixed Huffman
// codes bit reversed, length and distance codes with their extra bits.
// ============================================================================
module dfhe_front
    import dfhe_pkg::*;
(
    input  token_t   token_data,
    output q_entry_t entry
);

    logic [8:0]  len_c;
    logic [7:0]  lv;
    logic [7:0]  lv_sh;
    logic [2:0]  ltb;
    logic [2:0]  le;
    logic [4:0]  lsym;
    logic [8:0]  lcode;
    logic [3:0]  ln;
    logic [4:0]  lext;
    logic [15:0] dist_c;
    logic [14:0] dv;
    logic [3:0]  dtb;
    logic [3:0]  de;
    logic [4:0]  dcode;
    logic [12:0] dext;
    logic [8:0]  litcode;
    logic [3:0]  litn;
    logic [12:0] lpart;
    logic [17:0] dpart;
    logic [4:0]  l1;

    always_comb
    begin
        if (token_data.match_length < LEN_MIN)
        begin
            len_c = LEN_MIN;
        end
        else if (token_data.match_length > LEN_MAX)
        begin
            len_c = LEN_MAX;
        end
        else
        begin
            len_c = token_data.match_length;
        end
        lv    = 8'(len_c - LEN_MIN);
        ltb   = 3'(top_bit15({7'd0, lv}));
        le    = 3'd0;
        lv_sh = 8'd0;
        lsym  = 5'd0;
        lext  = 5'd0;
        if (len_c == LEN_MAX)
        begin
            lcode = LEN_MAX_CODE;
            ln    = 4'd8;
        end
        else if (lv < 8'd8)
        begin
            lcode = 9'(lv) + 9'd1;
            ln    = 4'd7;
        end
        else
        begin
            le    = ltb - 3'd2;
            lv_sh = lv >> le;
            lsym  = {le + 3'd1, 2'b00} + {3'd0, lv_sh[1:0]};
            lext  = 5'(lv & ((8'd1 << le) - 8'd1));
            if (lsym < LEN_CODE8_SPLIT)
            begin
                lcode = 9'(lsym) + 9'd1;
                ln    = 4'd7;
            end
            else
            begin
                lcode = LEN_CODE8_BASE + 9'(lsym) - 9'(LEN_CODE8_SPLIT);
                ln    = 4'd8;
            end
        end

        if (token_data.match_distance == 16'd0)
        begin
            dist_c = 16'd1;
        end
        else if (token_data.match_distance > DIST_MAX)
        begin
            dist_c = DIST_MAX;
        end
        else
        begin
            dist_c = token_data.match_distance;
        end
        dv  = 15'(dist_c - 16'd1);
        dtb = top_bit15(dv);
        if (dv < 15'd4)
        begin
            dcode = 5'(dv);
            de    = 4'd0;
            dext  = 13'd0;
        end
        else
        begin
            de    = dtb - 4'd1;
            dcode = {de + 4'd1, 1'b0} + {4'd0, dv[de]};
            dext  = 13'(dv & ((15'd1 << de) - 15'd1));
        end

        if (9'(token_data.literal_byte) < LIT_SPLIT)
        begin
            litcode = 9'(token_data.literal_byte) + LIT_CODE8_BASE;
            litn    = 4'd8;
        end
        else
        begin
            litcode = 9'(token_data.literal_byte) - LIT_SPLIT + LIT_CODE9_BASE;
            litn    = 4'd9;
        end

        lpart = 13'(rev_code(lcode, ln)) | (13'(lext) << ln);
        l1    = 5'(ln) + 5'(le);
        dpart = 18'(rev_code({4'd0, dcode}, 4'd5)) | (18'(dext) << 5);

        entry = '0;
        unique case (token_data.opcode)
            OP_HEADER:
            begin
                entry.tok_bits = {29'd0, 1'b1, token_data.final_block};
                entry.tok_len  = 6'd3;
            end
            OP_LITERAL:
            begin
                entry.tok_bits = TOK_BITS_W'(rev_code(litcode, litn));
                entry.tok_len  = 6'(litn);
            end
            OP_MATCH:
            begin
                entry.tok_bits = TOK_BITS_W'(lpart) | (TOK_BITS_W'(dpart) << l1);
                entry.tok_len  = 6'(l1) + 6'd5 + 6'(de);
            end
            OP_END:
            begin
                entry.tok_bits = TOK_BITS_W'(rev_code(EOB_CODE, EOB_CODE_LEN));
                entry.tok_len  = 6'(EOB_CODE_LEN);
                entry.flush    = 1'b1;
            end
            default:
            begin
                entry = '0;
            end
        endcase
    end

endmodule

// File: rtl/dfhe_queue.sv
// ============================================================================
// dfhe_queue
// Two-entry queue of coded tokens between the classifier and the packer.
// ============================================================================
module dfhe_queue
    import dfhe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  q_entry_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output q_entry_t rd_data
);

    q_entry_t   mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign wr_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/dfhe_packer.sv
// ============================================================================
// dfhe_packer
// Appends coded tokens to the pending bits and sends out every completed
// byte, one per cycle while code_ready stays high, through an output register.
// ============================================================================
module dfhe_packer
    import dfhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  q_entry_t   q_data,
    output logic       code_valid,
    input  logic       code_ready,
    output code_byte_t code_data
);

    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [TOK_LEN_W-1:0] cnt_reg;
    logic [TOK_LEN_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    code_byte_t           out_reg;
    code_byte_t           out_next;
    logic                 emit;
    logic                 pop;
    logic [TOK_LEN_W-1:0] sum;

    assign pop        = q_valid && (cnt_reg[TOK_LEN_W-1:3] == '0);
    assign emit       = (cnt_reg[TOK_LEN_W-1:3] != '0) && (!out_valid_reg || code_ready);
    assign q_ready    = pop;
    assign code_valid = out_valid_reg;
    assign code_data  = out_reg;

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !code_ready;
        sum            = cnt_reg + q_data.tok_len;
        if (emit)
        begin
            acc_next             = acc_reg >> 8;
            cnt_next             = cnt_reg - 6'd8;
            out_next.out_byte    = acc_reg[7:0];
            out_next.last_of_run = (cnt_reg < 6'd16);
            out_valid_next       = 1'b1;
        end
        else if (pop)
        begin
            acc_next = acc_reg | (ACC_W'(q_data.tok_bits) << cnt_reg[2:0]);
            if (q_data.flush && (sum[2:0] != 3'd0))
            begin
                cnt_next = {sum[TOK_LEN_W-1:3] + 3'd1, 3'd0};
            end
            else
            begin
                cnt_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: rtl/deflate_fixed_huffman_token_encoder_top.sv
// ============================================================================
// deflate_fixed_huffman_token_encoder_top
// Deflate fixed Huffman token encoder producing a least significant bit
// first byte stream.
// ============================================================================
// A request on the token channel carries one deflate token: block header,
// literal, length/distance match, or end of block with flush to a byte.
// A request on the code channel carries one completed stream byte; the
// last byte caused by a token has last_of_run set, and a token that
// completes no byte sends nothing.
// A token is coded in the cycle it is taken and goes into a two-entry
// queue, so token_ready only drops when that queue is full.
// The packer first merges a token into its pending bits and then sends
// out each completed byte in turn; it takes the next token only when
// fewer than eight bits are pending.
// The first byte of a token passes through the queue, the pending bits
// and the output register before it appears on the code channel.
// When the receiver holds code_ready low the byte waits in the output
// register, the packer stops, the queue fills and token_ready falls.
// Reset clears the pending bits, empties the queue and clears the output valid flag.
// ============================================================================
module deflate_fixed_huffman_token_encoder_top
    import dfhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       token_valid,
    output logic       token_ready,
    input  token_t     token_data,
    output logic       code_valid,
    input  logic       code_ready,
    output code_byte_t code_data
);

    q_entry_t entry;
    q_entry_t q_data;
    logic     q_valid;
    logic     q_ready;

    dfhe_front u_front
    (
        .token_data (token_data),
        .entry      (entry)
    );

    dfhe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (token_valid),
        .wr_ready (token_ready),
        .wr_data  (entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    dfhe_packer u_packer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_data  (code_data)
    );

endmodule
